// ----- sv/fba_pkg.sv -----
// Shared constants and helpers for the frame bitmap allocator.
// No dependencies; every other file of the block refers to this package.
package fba_pkg;

  localparam int WORD_BITS = 32;
  localparam int BIT_SEL_BITS = 5;
  localparam logic [WORD_BITS-1:0] FULL_WORD = 32'hffff_ffff;

  // Highest word count whose frames a 15-bit frame number can name.
  localparam int NAMEABLE_WORDS = 1024;
  localparam int SCAN_CNT_BITS = 11;

  localparam int FRAMES_BITS = 16;
  localparam int FRAME_IDX_BITS = 15;
  localparam logic [FRAMES_BITS-1:0] FRAMES_IN_USE_RESET = 16'd32768;

  // Operation codes.
  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  // Status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_FRAME = 2'd1;
  localparam logic [1:0] ST_RANGE    = 2'd2;

  // Position of the lowest clear bit of a word (0 when the word is full).
  function automatic logic [BIT_SEL_BITS-1:0] lowest_zero(input logic [WORD_BITS-1:0] w);
    logic [BIT_SEL_BITS-1:0] pos;
    pos = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!w[i]) begin
        pos = BIT_SEL_BITS'(i);
      end
    end
    return pos;
  endfunction

endpackage

// ----- sv/fba_req_if.sv -----
// Request channel of the frame bitmap allocator.
// Uses fba_pkg for field widths.
interface fba_req_if;
  logic                               valid;
  logic                               ready;
  logic [1:0]                         operation;
  logic [fba_pkg::FRAME_IDX_BITS-1:0] frame_index;
  logic                               user_access;
  logic                               writable;

  modport source (output valid, operation, frame_index, user_access, writable, input ready);
  modport sink   (input valid, operation, frame_index, user_access, writable, output ready);
endinterface

// ----- sv/fba_rsp_if.sv -----
// Response channel of the frame bitmap allocator.
// Uses fba_pkg for field widths.
interface fba_rsp_if;
  logic                               valid;
  logic                               ready;
  logic [1:0]                         status;
  logic [fba_pkg::FRAME_IDX_BITS-1:0] found_frame;
  logic [31:0]                        page_entry;
  logic                               frame_free;

  modport source (output valid, status, found_frame, page_entry, frame_free, input ready);
  modport sink   (input valid, status, found_frame, page_entry, frame_free, output ready);
endinterface

// ----- sv/fba_cfg_if.sv -----
// Configuration write channel carrying the frames_in_use register value.
// Uses fba_pkg for the register width.
interface fba_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [fba_pkg::FRAMES_BITS-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ----- sv/frame_bitmap_allocator.sv -----
// Frame bitmap allocator top level: request handling, scan control and the
// response register. Depends on fba_pkg, the three channel interfaces and fba_map_ram.
//
// Keeps one used bit per physical frame in a single-port-read memory of
// MAP_WORDS 32-bit words. After reset a clearing pass zeroes the map, one word
// per cycle, so no request is taken until the clearing pass has finished
// (configuration writes are taken at any time). A free or query request reads
// its word, modifies or tests it and responds. An allocate request streams one
// word per cycle out of the memory read port and scans at most
// min(frames_in_use / 32, MAP_WORDS, 1024) words, stopping at the first word
// that has a clear bit. Free or query requests whose index is out of range, or
// requests that carry an unused operation code, respond without touching the
// map. One request is worked at a time; the next one is taken while the
// previous response still waits in the output register.
module frame_bitmap_allocator #(
  parameter int MAP_WORDS = 1024,
  parameter int FRAME_BYTES_LOG2 = 12
) (
  input logic       clk,
  input logic       rst,
  fba_req_if.sink   req,
  fba_rsp_if.source rsp,
  fba_cfg_if.sink   cfg
);

  localparam int AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int SCAN_CAP =
    (MAP_WORDS < fba_pkg::NAMEABLE_WORDS) ? MAP_WORDS : fba_pkg::NAMEABLE_WORDS;
  localparam int FRAME_CAP = MAP_WORDS * fba_pkg::WORD_BITS;
  localparam int CW = fba_pkg::SCAN_CNT_BITS;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_MODIFY,
    S_PUT
  } state_t;

  state_t state;

  // Configuration register.
  logic [fba_pkg::FRAMES_BITS-1:0] frames_in_use;

  // Latched request.
  logic [1:0]                         op_q;
  logic [fba_pkg::FRAME_IDX_BITS-1:0] f_q;
  logic                               usr_q;
  logic                               wr_q;

  // Scan bookkeeping: scan_w is the next word to read, chk_w the word whose
  // data is on the memory output when chk_valid is set.
  logic [CW-1:0] scan_lim;
  logic [CW-1:0] scan_w;
  logic [CW-1:0] chk_w;
  logic          chk_valid;

  // Result waiting for the output register.
  logic [1:0]                         res_status;
  logic [fba_pkg::FRAME_IDX_BITS-1:0] res_found;
  logic [31:0]                        res_entry;
  logic                               res_free;

  // Memory port signals.
  logic                          ram_we;
  logic [AW-1:0]                 ram_waddr;
  logic [fba_pkg::WORD_BITS-1:0] ram_wdata;
  logic                          ram_re;
  logic [AW-1:0]                 ram_raddr;
  logic [fba_pkg::WORD_BITS-1:0] ram_rdata;
  logic                          ram_busy;

  logic          accept;
  logic          index_ok;
  logic [CW-1:0] lim_words;
  logic [CW-1:0] lim;
  logic          issuing;
  logic          hit;
  logic [fba_pkg::BIT_SEL_BITS-1:0] hit_bit;
  logic [fba_pkg::BIT_SEL_BITS-1:0] f_bit;
  logic [fba_pkg::FRAME_IDX_BITS-1:0] hit_frame;
  logic          out_free;

  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= fba_pkg::FRAMES_IN_USE_RESET;
    end else if (cfg.valid) begin
      frames_in_use <= cfg.data;
    end
  end

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;

  // A frame is addressable when it lies below both the configured count and
  // the size of the map.
  assign index_ok = (fba_pkg::FRAMES_BITS'(req.frame_index) < frames_in_use)
                    && (32'(req.frame_index) < FRAME_CAP);

  // Only words that lie wholly below frames_in_use are scanned.
  assign lim_words = frames_in_use[fba_pkg::FRAMES_BITS-1:fba_pkg::BIT_SEL_BITS];
  assign lim       = (lim_words < CW'(SCAN_CAP)) ? lim_words : CW'(SCAN_CAP);

  assign issuing   = (state == S_SCAN) && (scan_w < scan_lim);
  assign hit       = chk_valid && (ram_rdata != fba_pkg::FULL_WORD);
  assign hit_bit   = fba_pkg::lowest_zero(ram_rdata);
  assign hit_frame = {chk_w[fba_pkg::FRAME_IDX_BITS-fba_pkg::BIT_SEL_BITS-1:0], hit_bit};
  assign f_bit     = f_q[fba_pkg::BIT_SEL_BITS-1:0];

  // Read port: the scan counter during allocation, otherwise the word of the
  // frame that the incoming request names.
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = AW'(req.frame_index[fba_pkg::FRAME_IDX_BITS-1:fba_pkg::BIT_SEL_BITS]);
    if (state == S_SCAN) begin
      ram_re    = issuing;
      ram_raddr = AW'(scan_w);
    end else if (accept && index_ok
                 && (req.operation == fba_pkg::OP_FREE
                     || req.operation == fba_pkg::OP_QUERY)) begin
      ram_re = 1'b1;
    end
  end

  // Write port: mark the found frame used, or clear a freed frame.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = AW'(f_q[fba_pkg::FRAME_IDX_BITS-1:fba_pkg::BIT_SEL_BITS]);
    ram_wdata = ram_rdata & ~(fba_pkg::WORD_BITS'(1) << f_bit);
    if (state == S_SCAN) begin
      ram_we    = hit;
      ram_waddr = AW'(chk_w);
      ram_wdata = ram_rdata | (fba_pkg::WORD_BITS'(1) << hit_bit);
    end else if (state == S_MODIFY) begin
      ram_we = (op_q == fba_pkg::OP_FREE);
    end
  end

  fba_map_ram #(
    .DEPTH     (MAP_WORDS),
    .ADDR_BITS (AW)
  ) u_map (
    .clk   (clk),
    .rst   (rst),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata),
    .busy  (ram_busy)
  );

  assign out_free = !rsp.valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      chk_valid <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      // A response leaving the output register is replaced in the same cycle
      // when the next one is ready to load.
      if (rsp.valid && rsp.ready && state != S_PUT) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          if (!ram_busy) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            op_q       <= req.operation;
            f_q        <= req.frame_index;
            usr_q      <= req.user_access;
            wr_q       <= req.writable;
            res_found  <= '0;
            res_entry  <= '0;
            res_free   <= 1'b0;
            scan_lim   <= lim;
            scan_w     <= '0;
            chk_valid  <= 1'b0;
            case (req.operation)
              fba_pkg::OP_ALLOC: begin
                if (lim == '0) begin
                  res_status <= fba_pkg::ST_NO_FRAME;
                  state      <= S_PUT;
                end else begin
                  res_status <= fba_pkg::ST_OK;
                  state      <= S_SCAN;
                end
              end
              fba_pkg::OP_FREE, fba_pkg::OP_QUERY: begin
                if (index_ok) begin
                  res_status <= fba_pkg::ST_OK;
                  state      <= S_MODIFY;
                end else begin
                  res_status <= fba_pkg::ST_RANGE;
                  state      <= S_PUT;
                end
              end
              default: begin
                res_status <= fba_pkg::ST_OK;
                state      <= S_PUT;
              end
            endcase
          end
        end
        S_SCAN: begin
          chk_valid <= issuing && !hit;
          chk_w     <= scan_w;
          if (issuing) begin
            scan_w <= scan_w + 1'b1;
          end
          if (hit) begin
            res_found <= hit_frame;
            res_entry <= (32'(hit_frame) << FRAME_BYTES_LOG2)
                         | {29'd0, usr_q, wr_q, 1'b0};
            state     <= S_PUT;
          end else if (!issuing) begin
            // The last word has been checked and every word was full.
            res_status <= fba_pkg::ST_NO_FRAME;
            state      <= S_PUT;
          end
        end
        S_MODIFY: begin
          if (op_q == fba_pkg::OP_QUERY) begin
            res_free <= ~ram_rdata[f_bit];
          end
          state <= S_PUT;
        end
        S_PUT: begin
          if (out_free) begin
            rsp.valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Response payload registers.
  always_ff @(posedge clk) begin
    if (state == S_PUT && out_free) begin
      rsp.status      <= res_status;
      rsp.found_frame <= res_found;
      rsp.page_entry  <= res_entry;
      rsp.frame_free  <= res_free;
    end
  end

endmodule

// ----- sv/fba_map_ram.sv -----
// Bitmap word memory with one write and one registered read port, plus the
// clearing pass that zeroes every word after reset. Depends on fba_pkg.
module fba_map_ram #(
  parameter int DEPTH = 1024,
  parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          we,
  input  logic [ADDR_BITS-1:0]          waddr,
  input  logic [fba_pkg::WORD_BITS-1:0] wdata,
  input  logic                          re,
  input  logic [ADDR_BITS-1:0]          raddr,
  output logic [fba_pkg::WORD_BITS-1:0] rdata,
  output logic                          busy
);

  localparam logic [ADDR_BITS-1:0] LAST_ADDR = ADDR_BITS'(DEPTH - 1);

  logic [fba_pkg::WORD_BITS-1:0] mem [DEPTH];
  logic [ADDR_BITS-1:0]          clr_addr;

  // Clearing sequencer: one word per cycle until the last one is zeroed.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == LAST_ADDR) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_addr] <= '0;
    end else if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
